// ===== rtl/core/hpm_pkg.sv =====
// package for the harmonic phase mixer: widths, config codes, sine table and lookup
`default_nettype none

package hpm_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int PHASE_WIDTH    = 16;
    localparam int SINE_ADDR_BITS = 10;

    localparam int GAIN_WIDTH     = 16;
    localparam int GAIN_FRAC      = 8;
    localparam int PRODUCT_WIDTH  = PHASE_WIDTH + GAIN_WIDTH + 1;

    localparam int QIDX_WIDTH     = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN    = 1 << QIDX_WIDTH;
    localparam int MAG_WIDTH      = 15;
    localparam int TRIG_WIDTH     = MAG_WIDTH + 1;
    localparam int ROUND_SHIFT    = 15;

    localparam int CFG_IDX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH = (GAIN_WIDTH > PHASE_WIDTH) ? GAIN_WIDTH : PHASE_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HARMONIC_GAIN = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PHASE_OFFSET  = CFG_IDX_WIDTH'(1);

    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(256);

    // two pi in Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef logic [MAG_WIDTH-1:0] t_qtab [QUARTER_LEN];

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
        logic e;
    } t_pipe_en;

    // quarter wave sample: Q30 Taylor series, rounded to the 32767 peak scale
    function automatic logic [MAG_WIDTH-1:0] sine_q30_round(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        r = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[MAG_WIDTH-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int k = 0; k < QUARTER_LEN; k++) begin
            t[k] = sine_q30_round((TWO_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();
    localparam logic [MAG_WIDTH-1:0] QTAB_PEAK =
        sine_q30_round((TWO_PI_Q30 * 64'(QUARTER_LEN)) >> SINE_ADDR_BITS);

    // full-turn sine from the quarter table by symmetry
    function automatic logic signed [TRIG_WIDTH-1:0] sine_lookup(
        input logic [SINE_ADDR_BITS-1:0] addr
    );
        logic [1:0]            quad;
        logic [QIDX_WIDTH-1:0] r;
        logic [QIDX_WIDTH-1:0] rn;
        logic [MAG_WIDTH-1:0]  mag;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        r    = addr[QIDX_WIDTH-1:0];
        rn   = '0 - r;
        if (quad[0]) begin
            if (r == '0) begin
                mag = QTAB_PEAK;
            end else begin
                mag = QTAB[rn];
            end
        end else begin
            mag = QTAB[r];
        end
        if (quad[1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hpm_in_if.sv =====
// input stream channel: phase, complex sample and block end marker
`default_nettype none

interface hpm_in_if;
    import hpm_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [PHASE_WIDTH-1:0]  pll_phase;
    logic signed [SAMPLE_WIDTH-1:0] in_i;
    logic signed [SAMPLE_WIDTH-1:0] in_q;
    logic                           in_last;

    modport source (output valid, output pll_phase, output in_i, output in_q,
                    output in_last, input ready);
    modport sink   (input valid, input pll_phase, input in_i, input in_q,
                    input in_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hpm_out_if.sv =====
// output stream channel: rotated complex sample and block end marker
`default_nettype none

interface hpm_out_if;
    import hpm_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
    logic                           out_last;

    modport source (output valid, output out_i, output out_q, output out_last,
                    input ready);
    modport sink   (input valid, input out_i, input out_q, input out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/harmonic_phase_mixer_core.sv =====
// top level of the harmonic phase mixer: config registers, pipeline control, datapath
// usage:
//   i_in carries one beat per sample: pll_phase (turns, signed Q0.16), in_i, in_q
//   and in_last; o_out returns one beat per input beat in the same order with the
//   rotated, saturated sample and the copied last flag
//   config: pulse i_cfg_we with i_cfg_idx 0 for harmonic_gain (unsigned Q8.8) or
//   1 for phase_offset (Q0.16 turns); write only while the pipeline is empty
// timing:
//   five register stages: gain multiply, offset add and table address, sine and
//   cosine lookup, four sample products, then round and saturate into the output
//   register; a beat that is taken passes through these stages in that order
//   one beat per cycle sustained while o_out.ready is high, the pipeline then takes a new beat every cycle
// reset:
//   i_rst_n low clears all stage valid flags, sets gain to one and offset to zero
// back pressure:
//   each stage holds while it is full and the one after it cannot take data, so
//   bubbles are squeezed out; i_in.ready drops only once every stage is full and
//   o_out.ready is low, no beat is lost or repeated
`default_nettype none

module harmonic_phase_mixer_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    hpm_in_if.sink                                    i_in,
    hpm_out_if.source                                 o_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hpm_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  wire logic [hpm_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    import hpm_pkg::*;

    localparam int NUM_STAGES = 5;
    localparam int SIDE_STAGES = 3;

    // config registers
    logic [GAIN_WIDTH-1:0]  r_gain;
    logic [PHASE_WIDTH-1:0] r_offset;

    // stage valid flags, stage a first
    logic [NUM_STAGES-1:0] r_valid;
    t_pipe_en              en;

    // sample and last flag travelling beside the phase path
    logic signed [SAMPLE_WIDTH-1:0] r_smp_i [SIDE_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_smp_q [SIDE_STAGES];
    logic [NUM_STAGES-1:0]          r_last;

    logic [SINE_ADDR_BITS-1:0]    addr;
    logic signed [TRIG_WIDTH-1:0] sin_val;
    logic signed [TRIG_WIDTH-1:0] cos_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HARMONIC_GAIN: r_gain   <= i_cfg_data[GAIN_WIDTH-1:0];
                CFG_PHASE_OFFSET:  r_offset <= i_cfg_data[PHASE_WIDTH-1:0];
                default:           r_gain   <= r_gain;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        en.e = !r_valid[4] || o_out.ready;
        en.d = !r_valid[3] || en.e;
        en.c = !r_valid[2] || en.d;
        en.b = !r_valid[1] || en.c;
        en.a = !r_valid[0] || en.b;
    end

    assign i_in.ready = en.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en.a) begin
                r_valid[0] <= i_in.valid;
            end
            if (en.b) begin
                r_valid[1] <= r_valid[0];
            end
            if (en.c) begin
                r_valid[2] <= r_valid[1];
            end
            if (en.d) begin
                r_valid[3] <= r_valid[2];
            end
            if (en.e) begin
                r_valid[4] <= r_valid[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.a) begin
            r_smp_i[0] <= i_in.in_i;
            r_smp_q[0] <= i_in.in_q;
            r_last[0]  <= i_in.in_last;
        end
        if (en.b) begin
            r_smp_i[1] <= r_smp_i[0];
            r_smp_q[1] <= r_smp_q[0];
            r_last[1]  <= r_last[0];
        end
        if (en.c) begin
            r_smp_i[2] <= r_smp_i[1];
            r_smp_q[2] <= r_smp_q[1];
            r_last[2]  <= r_last[1];
        end
        if (en.d) begin
            r_last[3] <= r_last[2];
        end
        if (en.e) begin
            r_last[4] <= r_last[3];
        end
    end

    hpm_phase u_phase (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_pll_phase (i_in.pll_phase),
        .i_gain      (r_gain),
        .i_offset    (r_offset),
        .o_addr      (addr)
    );

    hpm_sincos u_sincos (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (addr),
        .o_sin  (sin_val),
        .o_cos  (cos_val)
    );

    hpm_rotate u_rotate (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_smp_i (r_smp_i[2]),
        .i_smp_q (r_smp_q[2]),
        .i_sin   (sin_val),
        .i_cos   (cos_val),
        .o_out_i (o_out.out_i),
        .o_out_q (o_out.out_q)
    );

    assign o_out.valid    = r_valid[4];
    assign o_out.out_last = r_last[4];

endmodule

`default_nettype wire

// ===== rtl/core/hpm_phase.sv =====
// phase path: harmonic gain multiply, then offset add and table address
`default_nettype none

module hpm_phase (
    input  wire logic                                      i_clk,
    input  wire hpm_pkg::t_pipe_en                         i_en,
    input  wire logic signed [hpm_pkg::PHASE_WIDTH-1:0]    i_pll_phase,
    input  wire logic [hpm_pkg::GAIN_WIDTH-1:0]            i_gain,
    input  wire logic [hpm_pkg::PHASE_WIDTH-1:0]           i_offset,
    output logic [hpm_pkg::SINE_ADDR_BITS-1:0]             o_addr
);
    import hpm_pkg::*;

    logic signed [PRODUCT_WIDTH-1:0] n_prod;
    logic signed [PRODUCT_WIDTH-1:0] r_prod;
    logic [PHASE_WIDTH-1:0]          n_phase;
    logic [SINE_ADDR_BITS-1:0]       n_addr;
    logic [SINE_ADDR_BITS-1:0]       r_addr;

    // signed phase times unsigned gain
    always_comb begin
        n_prod = $signed({{(GAIN_WIDTH + 1){i_pll_phase[PHASE_WIDTH-1]}}, i_pll_phase})
               * $signed({{(PHASE_WIDTH + 1){1'b0}}, i_gain});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_prod <= n_prod;
        end
    end

    // floor of the product plus the offset, wrapped to one turn
    always_comb begin
        n_phase = r_prod[PHASE_WIDTH+GAIN_FRAC-1:GAIN_FRAC] + i_offset;
    end

    generate
        if (PHASE_WIDTH >= SINE_ADDR_BITS) begin : g_addr_trunc
            always_comb begin
                n_addr = n_phase[PHASE_WIDTH-1 -: SINE_ADDR_BITS];
            end
        end else begin : g_addr_pad
            always_comb begin
                n_addr = {n_phase, {(SINE_ADDR_BITS - PHASE_WIDTH){1'b0}}};
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_addr <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

`default_nettype wire

// ===== rtl/core/hpm_sincos.sv =====
// sine and cosine lookup from the quarter wave table
`default_nettype none

module hpm_sincos (
    input  wire logic                                   i_clk,
    input  wire hpm_pkg::t_pipe_en                      i_en,
    input  wire logic [hpm_pkg::SINE_ADDR_BITS-1:0]     i_addr,
    output logic signed [hpm_pkg::TRIG_WIDTH-1:0]       o_sin,
    output logic signed [hpm_pkg::TRIG_WIDTH-1:0]       o_cos
);
    import hpm_pkg::*;

    logic [SINE_ADDR_BITS-1:0]    cos_addr;
    logic signed [TRIG_WIDTH-1:0] r_sin;
    logic signed [TRIG_WIDTH-1:0] r_cos;

    // cosine sits a quarter turn ahead
    assign cos_addr = i_addr + SINE_ADDR_BITS'(QUARTER_LEN);

    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            r_sin <= sine_lookup(i_addr);
            r_cos <= sine_lookup(cos_addr);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

// ===== rtl/core/hpm_rotate.sv =====
// complex rotation: four products, then sum, round and saturate
`default_nettype none

module hpm_rotate (
    input  wire logic                                     i_clk,
    input  wire hpm_pkg::t_pipe_en                        i_en,
    input  wire logic signed [hpm_pkg::SAMPLE_WIDTH-1:0]  i_smp_i,
    input  wire logic signed [hpm_pkg::SAMPLE_WIDTH-1:0]  i_smp_q,
    input  wire logic signed [hpm_pkg::TRIG_WIDTH-1:0]    i_sin,
    input  wire logic signed [hpm_pkg::TRIG_WIDTH-1:0]    i_cos,
    output logic signed [hpm_pkg::SAMPLE_WIDTH-1:0]       o_out_i,
    output logic signed [hpm_pkg::SAMPLE_WIDTH-1:0]       o_out_q
);
    import hpm_pkg::*;

    localparam int MUL_WIDTH = SAMPLE_WIDTH + TRIG_WIDTH;
    localparam int ACC_WIDTH = MUL_WIDTH + 2;
    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
        ACC_WIDTH'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        ACC_WIDTH'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    logic signed [MUL_WIDTH-1:0]    r_ic;
    logic signed [MUL_WIDTH-1:0]    r_qs;
    logic signed [MUL_WIDTH-1:0]    r_is;
    logic signed [MUL_WIDTH-1:0]    r_qc;
    logic signed [ACC_WIDTH-1:0]    n_re;
    logic signed [ACC_WIDTH-1:0]    n_im;
    logic signed [ACC_WIDTH-1:0]    n_re_sh;
    logic signed [ACC_WIDTH-1:0]    n_im_sh;
    logic signed [SAMPLE_WIDTH-1:0] n_out_i;
    logic signed [SAMPLE_WIDTH-1:0] n_out_q;
    logic signed [SAMPLE_WIDTH-1:0] r_out_i;
    logic signed [SAMPLE_WIDTH-1:0] r_out_q;

    always_ff @(posedge i_clk) begin
        if (i_en.d) begin
            r_ic <= MUL_WIDTH'(i_smp_i) * MUL_WIDTH'(i_cos);
            r_qs <= MUL_WIDTH'(i_smp_q) * MUL_WIDTH'(i_sin);
            r_is <= MUL_WIDTH'(i_smp_i) * MUL_WIDTH'(i_sin);
            r_qc <= MUL_WIDTH'(i_smp_q) * MUL_WIDTH'(i_cos);
        end
    end

    // round halves upward, arithmetic shift is the floor
    always_comb begin
        n_re    = ACC_WIDTH'(r_ic) - ACC_WIDTH'(r_qs) + ROUND_BIAS;
        n_im    = ACC_WIDTH'(r_is) + ACC_WIDTH'(r_qc) + ROUND_BIAS;
        n_re_sh = n_re >>> ROUND_SHIFT;
        n_im_sh = n_im >>> ROUND_SHIFT;
        if (n_re_sh > SAT_HI) begin
            n_out_i = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (n_re_sh < SAT_LO) begin
            n_out_i = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            n_out_i = n_re_sh[SAMPLE_WIDTH-1:0];
        end
        if (n_im_sh > SAT_HI) begin
            n_out_q = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (n_im_sh < SAT_LO) begin
            n_out_q = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            n_out_q = n_im_sh[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.e) begin
            r_out_i <= n_out_i;
            r_out_q <= n_out_q;
        end
    end

    assign o_out_i = r_out_i;
    assign o_out_q = r_out_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for harmonic_phase_mixer_core: directed and random beats against a predictor
`timescale 1ns / 1ps

module tb_top;
    import hpm_pkg::*;

    localparam int QTR          = 1 << (SINE_ADDR_BITS - 2);
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 80;

    typedef struct {
        logic signed [PHASE_WIDTH-1:0]  phase;
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           last;
    } t_sample;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           last;
    } t_rotated;

    // own copy of the oscillator and the two registers, one expectation per accepted beat
    class mixer_scoreboard;
        int                     quarter_wave[QTR + 1];
        logic [GAIN_WIDTH-1:0]  gain_q88;
        logic [PHASE_WIDTH-1:0] offset_turns;
        t_rotated               expected_rotations[$];
        int                     mismatches;

        function new();
            for (int k = 0; k <= QTR; k++) begin
                quarter_wave[k] = quarter_point((TWO_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS);
            end
            gain_q88     = GAIN_WIDTH'(256);
            offset_turns = '0;
            mismatches   = 0;
        endfunction

        // taylor series in q30, scaled to the 32767 peak
        function int quarter_point(longint unsigned x);
            longint unsigned x2;
            longint unsigned term;
            longint unsigned r;
            longint          sum;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (longint unsigned n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            return int'(r);
        endfunction

        function longint sine_at(logic [SINE_ADDR_BITS-1:0] addr);
            logic [1:0] quad;
            int         r;
            longint     v;
            quad = addr[SINE_ADDR_BITS-1 -: 2];
            r    = int'(addr[SINE_ADDR_BITS-3:0]);
            v    = quad[0] ? quarter_wave[QTR - r] : quarter_wave[r];
            return quad[1] ? -v : v;
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] round_clamp(longint acc);
            longint hi;
            longint v;
            hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
            v  = (acc + 16384) >>> 15;
            if (v > hi) begin
                v = hi;
            end
            if (v < -hi - 1) begin
                v = -hi - 1;
            end
            return SAMPLE_WIDTH'(v);
        endfunction

        function t_rotated rotate_sample(t_sample s);
            logic signed [PRODUCT_WIDTH-1:0] prod;
            logic [PHASE_WIDTH-1:0]          ph;
            logic [SINE_ADDR_BITS-1:0]       addr;
            longint                          sn;
            longint                          cs;
            longint                          xi;
            longint                          xq;
            t_rotated                        r;
            prod = s.phase * $signed({1'b0, gain_q88});
            ph   = prod[GAIN_FRAC +: PHASE_WIDTH] + offset_turns;
            addr = ph[PHASE_WIDTH-1 -: SINE_ADDR_BITS];
            sn   = sine_at(addr);
            cs   = sine_at(SINE_ADDR_BITS'(addr + QTR));
            xi   = s.re;
            xq   = s.im;
            r.re   = round_clamp(xi * cs - xq * sn);
            r.im   = round_clamp(xi * sn + xq * cs);
            r.last = s.last;
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] v);
            if (idx == CFG_HARMONIC_GAIN) begin
                gain_q88 = v[GAIN_WIDTH-1:0];
            end else if (idx == CFG_PHASE_OFFSET) begin
                offset_turns = v[PHASE_WIDTH-1:0];
            end
        endfunction

        function void note_sample(t_sample s);
            expected_rotations.push_back(rotate_sample(s));
        endfunction

        function void check_rotated(t_rotated got);
            t_rotated want;
            if (expected_rotations.size() == 0) begin
                $error("unexpected output beat: out_i %0d out_q %0d", got.re, got.im);
                mismatches++;
                return;
            end
            want = expected_rotations.pop_front();
            if (got.re !== want.re) begin
                $error("out_i mismatch: expected %0d, actual %0d", want.re, got.re);
                mismatches++;
            end
            if (got.im !== want.im) begin
                $error("out_q mismatch: expected %0d, actual %0d", want.im, got.im);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("out_last mismatch: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    hpm_in_if  in_ch ();
    hpm_out_if out_ch ();

    mixer_scoreboard sb = new();

    // idle chances in percent per cycle, set per phase by the main sequence
    int tx_idle_pct;
    int rx_idle_pct;
    // non-zero asks the receiver to hold off for that many cycles
    int stall_req;
    int cycles;

    harmonic_phase_mixer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far above the length of the slowest legal run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge, inputs only change at the falling one
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            sb.note_sample('{in_ch.pll_phase, in_ch.in_i, in_ch.in_q, in_ch.in_last});
        end
        if (out_ch.valid && out_ch.ready) begin
            sb.check_rotated('{out_ch.out_i, out_ch.out_q, out_ch.out_last});
        end
    end

    // receiver: random back pressure, plus one long hold-off counted here on request
    initial begin : receiver
        int stretch;
        stretch      = 0;
        stall_req    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req > 0) begin
                stretch   = stall_req;
                stall_req = 0;
            end
            if (stretch > 0) begin
                out_ch.ready <= 1'b0;
                stretch--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_sample sample_of(int ph, int re, int im, bit last);
        t_sample s;
        s.phase = PHASE_WIDTH'(ph);
        s.re    = SAMPLE_WIDTH'(re);
        s.im    = SAMPLE_WIDTH'(im);
        s.last  = last;
        return s;
    endfunction

    // mostly full-range values, with the corners of the sample range now and then
    function automatic logic signed [SAMPLE_WIDTH-1:0] random_component();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.phase = PHASE_WIDTH'($urandom);
        s.re    = random_component();
        s.im    = random_component();
        s.last  = ($urandom_range(7) == 0);
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pll_phase <= s.phase;
        in_ch.in_i      <= s.re;
        in_ch.in_q      <= s.im;
        in_ch.in_last   <= s.last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // wait for every expected beat, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // both registers back to back, write enable held across the pair
    task automatic write_regs(input int gain, input int offset);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HARMONIC_GAIN;
        cfg_data <= CFG_DATA_WIDTH'(gain);
        sb.write_reg(CFG_HARMONIC_GAIN, CFG_DATA_WIDTH'(gain));
        @(negedge i_clk);
        cfg_idx  <= CFG_PHASE_OFFSET;
        cfg_data <= CFG_DATA_WIDTH'(offset);
        sb.write_reg(CFG_PHASE_OFFSET, CFG_DATA_WIDTH'(offset));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_run(input int n, input bit with_stall);
        for (int k = 0; k < n; k++) begin
            if (with_stall && k == n / 2) begin
                stall_req = STALL_CYCLES;
            end
            send_sample(random_sample());
        end
        drain();
    endtask

    initial begin : main_seq
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.pll_phase = '0;
        in_ch.in_i      = '0;
        in_ch.in_q      = '0;
        in_ch.in_last   = 1'b0;
        tx_idle_pct     = 28;
        rx_idle_pct     = 88;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: gain of one, no offset
        send_sample(sample_of(0, 32767, 0, 0));
        // quarter turn lands on the table peak
        send_sample(sample_of(16'h4000, 1000, -1000, 0));
        send_sample(sample_of(16'h8000, -32768, -32768, 1));
        send_sample(sample_of(16'hc000, 32767, 32767, 0));
        // eighth turn with full scale corners, both saturation directions
        send_sample(sample_of(16'h2000, -32768, -32768, 0));
        send_sample(sample_of(16'h2000, 32767, 32767, 0));
        send_sample(sample_of(16'h2000, 32767, -32768, 1));
        // low phase bits below the table resolution
        send_sample(sample_of(16'h003f, 12345, -12345, 1));
        send_sample(sample_of(16'h7fff, -1, 1, 0));
        // tiny inputs where rounding halves matters
        send_sample(sample_of(16'hffff, 1, 1, 1));
        send_sample(sample_of(16'h6000, 16384, 16384, 0));
        send_sample(sample_of(16'h8001, 0, -32768, 0));
        send_sample(sample_of(16'h1234, 16'h5555, 16'haaaa, 1));
        drain();

        // largest gain, most negative offset
        write_regs(65535, -32768);
        send_sample(sample_of(16'h7fff, 32767, -32768, 0));
        send_sample(sample_of(16'h8000, -32768, 32767, 1));
        send_sample(sample_of(16'h0101, 32767, 32767, 0));
        send_sample(sample_of(16'hffff, -32768, -32768, 1));
        drain();

        // zero gain leaves the offset alone, largest positive offset
        write_regs(0, 32767);
        send_sample(sample_of(16'h4321, 20000, -20000, 0));
        send_sample(sample_of(16'h8000, -32768, 32767, 1));
        drain();

        // second harmonic, quarter turn offset
        write_regs(512, 16'h4000);
        send_sample(sample_of(16'h2000, 32767, 0, 0));
        send_sample(sample_of(16'he000, 0, 32767, 0));
        send_sample(sample_of(16'h9000, -20000, 30000, 1));
        drain();

        // random part: slow receiver first
        write_regs(256, 0);
        random_run(220, 1'b0);
        write_regs($urandom_range(65535), $urandom_range(65535));
        random_run(160, 1'b0);

        // then a slow sender
        tx_idle_pct = 88;
        rx_idle_pct = 28;
        write_regs(65535, -32768);
        random_run(170, 1'b0);
        write_regs(256 * $urandom_range(2, 8), $urandom_range(65535));
        random_run(170, 1'b0);

        // full rate both sides, one long hold-off to back the pipeline up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(0, 32767);
        random_run(160, 1'b0);
        write_regs($urandom_range(65535), $urandom_range(65535));
        random_run(170, 1'b1);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hpm_pkg.sv
rtl/core/hpm_in_if.sv
rtl/core/hpm_out_if.sv
rtl/core/hpm_phase.sv
rtl/core/hpm_sincos.sv
rtl/core/hpm_rotate.sv
rtl/core/harmonic_phase_mixer_core.sv
dv/tb_top.sv
